// File: hdl/mtvs_pkg.sv
// Package for the mt19937 test value source: generator constants, output
// tempering and the mod-4097 value mapping. No dependencies.
package mtvs_pkg;

  localparam int unsigned MtWords = 624;
  localparam int unsigned IdxW = $clog2(MtWords);

  localparam logic [IdxW-1:0] MtN     = IdxW'(MtWords);
  localparam logic [IdxW-1:0] MtLast  = IdxW'(MtWords - 1);
  localparam logic [IdxW-1:0] MtShift = IdxW'(397);

  localparam logic [31:0] MtMatrix   = 32'h9908_B0DF;
  localparam logic [31:0] MtUpper    = 32'h8000_0000;
  localparam logic [31:0] MtLower    = 32'h7FFF_FFFF;
  localparam logic [31:0] MtInitMult = 32'd1812433253;
  localparam logic [31:0] ResetSeed  = 32'd5489;

  localparam logic signed [13:0] ValueMod    = 14'sd4097;
  localparam logic signed [13:0] ValueOffset = 14'sd2048;

  function automatic logic [31:0] mt_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // 4096 == -1 (mod 4097): fold the 12-bit digits with alternating sign.
  function automatic logic signed [12:0] mt_value(input logic [31:0] w);
    logic signed [13:0] t;
    t = $signed({2'b00, w[11:0]}) + $signed({6'b0, w[31:24]})
      - $signed({2'b00, w[23:12]});
    if (t < 0) begin
      t = t + ValueMod;
    end else if (t >= ValueMod) begin
      t = t - ValueMod;
    end
    t = t - ValueOffset;
    return t[12:0];
  endfunction

endpackage

// File: hdl/mt19937_test_value_source.sv
// Mersenne Twister (mt19937) test value source: 624-word state memory,
// a sequencer for seeding, twisting and drawing. Depends on mtvs_pkg.
//
// Channels:
//   cfg   : cfg_valid/cfg_ready with seed; always ready. The new seed is used
//           at the next restart or at the first word after reset.
//   in    : in_valid/in_ready with restart; ready only while the sequencer is
//           idle. restart=1 reseeds the state before the value is drawn.
//   out   : out_valid/out_ready with value, signed count of 1/512 steps in
//           -2048..2048, held in an output register until taken.
// Sequence per word, acceptance to out_valid; in_ready returns with out_valid:
//   plain draw : state read, tempering, mod 4097.
//   with twist : a twist pass over the 624 words first, each word read and
//                rewritten through the two-read, one-write memory, then the draw.
//   with reseed: the seeding chain first, one word at a time through the
//                single 32x32 multiplier, then the twist and the draw.
// A twist is due every 624 draws. Reset clears the sequencer, sets the seed
// to 5489 and marks the generator unseeded. A stalled receiver holds the
// finished word; the sequencer waits for the output register before
// loading the next one.
module mt19937_test_value_source
  import mtvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        seed,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [12:0] value
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_FIRST,
    S_SEED_MUL,
    S_SEED_ADD,
    S_TW_PRE,
    S_TW_LOAD,
    S_TW_RD,
    S_TW_CALC,
    S_DRAW_RD,
    S_DRAW_TMP,
    S_DRAW_MOD
  } state_t;

  state_t          state;
  logic [31:0]     cur_seed;
  logic            seeded;
  logic [IdxW-1:0] pos;
  logic [IdxW-1:0] idx;
  logic [31:0]     prev;
  logic [31:0]     prod;
  logic [31:0]     cur;
  logic [31:0]     tmp;

  logic [31:0]     mem [MtWords];
  logic [31:0]     rdata_a;
  logic [31:0]     rdata_b;
  logic [IdxW-1:0] addr_a;
  logic [IdxW-1:0] addr_b;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [31:0]     mem_wdata;

  logic [IdxW-1:0] idx_plus1;
  logic [IdxW-1:0] idx_plusm;
  logic [IdxW-1:0] idx_sum;
  logic [31:0]     seed_word;
  logic [31:0]     tw_y;
  logic [31:0]     tw_word;
  logic            in_acc;
  logic            out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state == S_DRAW_MOD) && (!out_valid || out_ready);

  assign idx_plus1 = (idx == MtLast) ? '0 : idx + IdxW'(1);
  assign idx_sum   = idx + MtShift;
  assign idx_plusm = (idx_sum >= MtN) ? idx_sum - MtN : idx_sum;

  assign seed_word = prod + {{(32-IdxW){1'b0}}, idx};
  assign tw_y      = (cur & MtUpper) | (rdata_a & MtLower);
  assign tw_word   = rdata_b ^ (tw_y >> 1) ^ (tw_y[0] ? MtMatrix : 32'h0);

  always_comb begin
    addr_a    = idx_plus1;
    addr_b    = idx_plusm;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = tw_word;
    unique case (state)
      S_TW_PRE:  addr_a = '0;
      S_DRAW_RD: addr_a = pos;
      S_SEED_FIRST: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = cur_seed;
      end
      S_SEED_ADD: begin
        mem_we    = 1'b1;
        mem_wdata = seed_word;
      end
      S_TW_CALC: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_a <= mem[addr_a];
    rdata_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_seed  <= ResetSeed;
      seeded    <= 1'b0;
      pos       <= MtN;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cur_seed <= seed;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            priority if (restart || !seeded) begin
              state <= S_SEED_FIRST;
            end else if (pos >= MtN) begin
              state <= S_TW_PRE;
            end else begin
              state <= S_DRAW_RD;
            end
          end
        end
        S_SEED_FIRST: begin
          prev   <= cur_seed;
          idx    <= IdxW'(1);
          seeded <= 1'b1;
          state  <= S_SEED_MUL;
        end
        S_SEED_MUL: begin
          prod  <= MtInitMult * (prev ^ (prev >> 30));
          state <= S_SEED_ADD;
        end
        S_SEED_ADD: begin
          prev <= seed_word;
          if (idx == MtLast) begin
            idx   <= '0;
            pos   <= MtN;
            state <= S_TW_PRE;
          end else begin
            idx   <= idx + IdxW'(1);
            state <= S_SEED_MUL;
          end
        end
        S_TW_PRE: begin
          idx   <= '0;
          state <= S_TW_LOAD;
        end
        S_TW_LOAD: begin
          cur   <= rdata_a;
          state <= S_TW_CALC;
        end
        S_TW_RD: state <= S_TW_CALC;
        S_TW_CALC: begin
          cur <= rdata_a;
          if (idx == MtLast) begin
            idx   <= '0;
            pos   <= '0;
            state <= S_DRAW_RD;
          end else begin
            idx   <= idx + IdxW'(1);
            state <= S_TW_RD;
          end
        end
        S_DRAW_RD: begin
          pos   <= pos + IdxW'(1);
          state <= S_DRAW_TMP;
        end
        S_DRAW_TMP: begin
          tmp   <= mt_temper(rdata_a);
          state <= S_DRAW_MOD;
        end
        S_DRAW_MOD: begin
          if (out_load) begin
            value <= mt_value(tmp);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) pos <= MtN)
    else $error("word position past end of state");

  assert property (@(posedge clk) disable iff (rst) in_acc |=> !in_ready)
    else $error("new word taken while busy");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAW_RD) |-> (seeded && pos < MtN))
    else $error("draw from unseeded or untwisted state");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DRAW_MOD))
    else $error("output word outside draw sequence");

endmodule
